// ===== sv/tcac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcac_pkg
// Shared widths, register indexes and types for the touch coordinate
// averaging and calibration block.
// ----------------------------------------------------------------------------
package tcac_pkg;

   localparam int BURST_PAIRS  = 16;
   localparam int SAMPLE_BITS  = 12;
   localparam int SAMPLE_SHIFT = 3;
   localparam int WORD_W       = 16;
   localparam int SUM_W        = 16;
   localparam int COUNT_W      = $clog2(BURST_PAIRS);
   localparam int PROD_W       = 2 * SAMPLE_BITS;
   localparam int REM_W        = SAMPLE_BITS + 1;
   localparam int DIV_CNT_W    = $clog2(PROD_W);
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SIZE    = 3'd5;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [SUM_W-1:0]       sum_type;

   localparam sample_type X_RAW_MIN_RST = 12'd0;
   localparam sample_type X_RAW_MAX_RST = 12'd4095;
   localparam sample_type X_SIZE_RST    = 12'd239;
   localparam sample_type Y_RAW_MIN_RST = 12'd0;
   localparam sample_type Y_RAW_MAX_RST = 12'd4095;
   localparam sample_type Y_SIZE_RST    = 12'd319;

endpackage

// ===== sv/tcac_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcac interfaces
// Valid/ready channels for touch word pairs, coordinate results and
// register writes.
// ----------------------------------------------------------------------------
interface tcac_req_if;
   logic                valid;
   logic                ready;
   tcac_pkg::word_type  y_word;
   tcac_pkg::word_type  x_word;
   modport source (output valid, output y_word, output x_word, input ready);
   modport sink (input valid, input y_word, input x_word, output ready);
endinterface

interface tcac_rsp_if;
   logic                  valid;
   logic                  ready;
   tcac_pkg::sample_type  x_pos;
   tcac_pkg::sample_type  y_pos;
   logic                  span_fault;
   modport source (output valid, output x_pos, output y_pos, output span_fault,
                   input ready);
   modport sink (input valid, input x_pos, input y_pos, input span_fault,
                 output ready);
endinterface

interface tcac_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tcac_pkg::CSR_IDX_W-1:0]      index;
   tcac_pkg::sample_type                data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/touch_coordinate_average_calibrate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_coordinate_average_calibrate
// Averages a burst of 16 touch word pairs and maps the mean per axis onto
// screen coordinates with one shared multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    y_word[15:0], x_word[15:0]
//  rsp_bus   out  valid/ready    x_pos[11:0], y_pos[11:0], span_fault
//  csr_bus   in   valid/ready    index[2:0], data[11:0]
//
//  A pair that does not close a burst is only added to the running sums.
//  After the closing pair the block works per axis through one multiply,
//  24 restoring divide steps and one clamp, then loads the result; it takes no pair meanwhile.
//  The result sits in an output register, so a stalled rsp_bus only holds
//  the block once the next burst has finished. Reset is synchronous.
// ----------------------------------------------------------------------------
module touch_coordinate_average_calibrate (
   input  logic        clock,
   input  logic        reset,
   tcac_req_if.sink    req_bus,
   tcac_rsp_if.source  rsp_bus,
   tcac_csr_if.sink    csr_bus
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [tcac_pkg::COUNT_W-1:0] LAST_PAIR =
      tcac_pkg::COUNT_W'(tcac_pkg::BURST_PAIRS - 1);
   localparam logic [tcac_pkg::DIV_CNT_W-1:0] LAST_STEP =
      tcac_pkg::DIV_CNT_W'(tcac_pkg::PROD_W - 1);

   logic [2:0] state_ff, state_in;

   tcac_pkg::sample_type x_raw_min_ff, x_raw_max_ff, x_size_ff;
   tcac_pkg::sample_type y_raw_min_ff, y_raw_max_ff, y_size_ff;

   logic [tcac_pkg::COUNT_W-1:0] pair_count_ff, pair_count_in;
   tcac_pkg::sum_type sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   tcac_pkg::sum_type sum_x_next, sum_y_next;
   tcac_pkg::sample_type mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;

   logic axis_ff, axis_in;
   logic fault_ff, fault_in;
   logic zero_ff, zero_in;
   logic [tcac_pkg::PROD_W-1:0] quo_ff, quo_in;
   tcac_pkg::sample_type rem_ff, rem_in;
   tcac_pkg::sample_type den_ff, den_in;
   logic [tcac_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   tcac_pkg::sample_type px_ff, px_in, py_ff, py_in;

   logic rsp_valid_ff, rsp_valid_in;
   tcac_pkg::sample_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic rsp_fault_ff, rsp_fault_in;

   logic req_take;
   tcac_pkg::sample_type sel_mean, sel_min, sel_max, sel_size;
   logic [tcac_pkg::REM_W-1:0] diff, span;
   tcac_pkg::sample_type diff_mag, span_mag;
   logic [tcac_pkg::REM_W-1:0] rem_shift;
   logic rem_ge;
   tcac_pkg::sample_type clamped;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.x_pos      = rsp_x_ff;
   assign rsp_bus.y_pos      = rsp_y_ff;
   assign rsp_bus.span_fault = rsp_fault_ff;

   assign sum_x_next = sum_x_ff + tcac_pkg::SUM_W'(
      req_bus.x_word[tcac_pkg::SAMPLE_SHIFT +: tcac_pkg::SAMPLE_BITS]);
   assign sum_y_next = sum_y_ff + tcac_pkg::SUM_W'(
      req_bus.y_word[tcac_pkg::SAMPLE_SHIFT +: tcac_pkg::SAMPLE_BITS]);

   // axis operand select for the shared unit
   always_comb begin
      if (axis_ff) begin
         sel_mean = mean_y_ff;
         sel_min  = y_raw_min_ff;
         sel_max  = y_raw_max_ff;
         sel_size = y_size_ff;
      end else begin
         sel_mean = mean_x_ff;
         sel_min  = x_raw_min_ff;
         sel_max  = x_raw_max_ff;
         sel_size = x_size_ff;
      end
   end

   assign diff     = {1'b0, sel_mean} - {1'b0, sel_min};
   assign span     = {1'b0, sel_max} - {1'b0, sel_min};
   assign diff_mag = diff[tcac_pkg::REM_W-1] ? tcac_pkg::SAMPLE_BITS'(-diff)
                                             : diff[tcac_pkg::SAMPLE_BITS-1:0];
   assign span_mag = span[tcac_pkg::REM_W-1] ? tcac_pkg::SAMPLE_BITS'(-span)
                                             : span[tcac_pkg::SAMPLE_BITS-1:0];

   assign rem_shift = {rem_ff, quo_ff[tcac_pkg::PROD_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   assign clamped = zero_ff ? '0 :
                    (quo_ff >= tcac_pkg::PROD_W'(sel_size)) ? sel_size :
                    quo_ff[tcac_pkg::SAMPLE_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      pair_count_in = pair_count_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      mean_x_in     = mean_x_ff;
      mean_y_in     = mean_y_ff;
      axis_in       = axis_ff;
      fault_in      = fault_ff;
      zero_in       = zero_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_fault_in  = rsp_fault_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (pair_count_ff == LAST_PAIR) begin
                  mean_x_in     = tcac_pkg::SAMPLE_BITS'(sum_x_next / tcac_pkg::BURST_PAIRS);
                  mean_y_in     = tcac_pkg::SAMPLE_BITS'(sum_y_next / tcac_pkg::BURST_PAIRS);
                  pair_count_in = '0;
                  sum_x_in      = '0;
                  sum_y_in      = '0;
                  axis_in       = 1'b0;
                  fault_in      = 1'b0;
                  state_in      = ST_MUL;
               end else begin
                  pair_count_in = pair_count_ff + 1'b1;
                  sum_x_in      = sum_x_next;
                  sum_y_in      = sum_y_next;
               end
            end
         end
         ST_MUL: begin
            quo_in   = tcac_pkg::PROD_W'(diff_mag) * tcac_pkg::PROD_W'(sel_size);
            den_in   = span_mag;
            zero_in  = (span_mag == '0) || (diff_mag == '0) ||
                       (diff[tcac_pkg::REM_W-1] != span[tcac_pkg::REM_W-1]);
            fault_in = fault_ff || (span_mag == '0);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in  = {quo_ff[tcac_pkg::PROD_W-2:0], rem_ge};
            rem_in  = rem_ge ? tcac_pkg::SAMPLE_BITS'(rem_shift - {1'b0, den_ff})
                             : rem_shift[tcac_pkg::SAMPLE_BITS-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (axis_ff) begin
               py_in    = clamped;
               state_in = ST_OUT;
            end else begin
               px_in    = clamped;
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_fault_in = fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pair_count_ff <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= 1'b0;
         fault_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pair_count_ff <= pair_count_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         rsp_valid_ff  <= rsp_valid_in;
         axis_ff       <= axis_in;
         fault_ff      <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_x_ff    <= mean_x_in;
      mean_y_ff    <= mean_y_in;
      zero_ff      <= zero_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      step_ff      <= step_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_raw_min_ff <= tcac_pkg::X_RAW_MIN_RST;
         x_raw_max_ff <= tcac_pkg::X_RAW_MAX_RST;
         x_size_ff    <= tcac_pkg::X_SIZE_RST;
         y_raw_min_ff <= tcac_pkg::Y_RAW_MIN_RST;
         y_raw_max_ff <= tcac_pkg::Y_RAW_MAX_RST;
         y_size_ff    <= tcac_pkg::Y_SIZE_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            tcac_pkg::CSR_X_RAW_MIN: x_raw_min_ff <= csr_bus.data;
            tcac_pkg::CSR_X_RAW_MAX: x_raw_max_ff <= csr_bus.data;
            tcac_pkg::CSR_X_SIZE:    x_size_ff    <= csr_bus.data;
            tcac_pkg::CSR_Y_RAW_MIN: y_raw_min_ff <= csr_bus.data;
            tcac_pkg::CSR_Y_RAW_MAX: y_raw_max_ff <= csr_bus.data;
            tcac_pkg::CSR_Y_SIZE:    y_size_ff    <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/tb_touch_coordinate_average_calibrate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_coordinate_average_calibrate
// Drives bursts of touch word pairs through the averaging and calibration
// block under several calibration settings and handshake paces, predicts
// each coordinate result and checks it field by field as it leaves.
// ----------------------------------------------------------------------------
module tb_touch_coordinate_average_calibrate;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 72;
   localparam int PRESSURE_PHASE = 2;

   localparam logic [tcac_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef enum {PACE_FULL, PACE_SRC_GAPS, PACE_SNK_STALLS, PACE_BOTH} pace_type;

   typedef struct packed {
      tcac_pkg::word_type y_word;
      tcac_pkg::word_type x_word;
   } touch_pair_type;

   typedef struct packed {
      tcac_pkg::sample_type x_pos;
      tcac_pkg::sample_type y_pos;
      logic                 span_fault;
   } coord_type;

   logic clock;
   logic reset;

   tcac_req_if req_bus ();
   tcac_rsp_if rsp_bus ();
   tcac_csr_if csr_bus ();

   touch_coordinate_average_calibrate uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   touch_pair_type pending_pairs [$];
   coord_type      expected_coords [$];
   coord_type      want_coord;

   tcac_pkg::sample_type cal_x_min, cal_x_max, cal_x_size;
   tcac_pkg::sample_type cal_y_min, cal_y_max, cal_y_size;
   tcac_pkg::sum_type    run_sum_x, run_sum_y;
   int                   burst_fill;

   tcac_pkg::sample_type calib_next [8];
   int         gen_pairs;
   bit         burst_noise;
   int         aim_x, aim_y, spread;

   int src_idle_pct;
   int snk_stall_pct;
   logic hold_go;
   int hold_left;
   int quiet_cycles;

   int mismatch_count;
   int pairs_sent;
   int results_seen;
   int settings_count;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic tcac_pkg::sample_type sample_of(input tcac_pkg::word_type w);
      return tcac_pkg::sample_type'(w >> tcac_pkg::SAMPLE_SHIFT);
   endfunction

   function automatic tcac_pkg::sample_type map_axis(input tcac_pkg::sample_type mean,
                                                     input tcac_pkg::sample_type lo,
                                                     input tcac_pkg::sample_type hi,
                                                     input tcac_pkg::sample_type size,
                                                     inout bit fault);
      longint num;
      longint den;
      longint q;
      num = (longint'(mean) - longint'(lo)) * longint'(size);
      den = longint'(hi) - longint'(lo);
      if (den == 0) begin
         fault = 1'b1;
         return '0;
      end
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num <= 0) return '0;
      q = num / den;
      if (q >= longint'(size)) return size;
      return tcac_pkg::sample_type'(q);
   endfunction

   task automatic absorb_pair(input tcac_pkg::word_type y_word,
                              input tcac_pkg::word_type x_word);
      coord_type            res;
      bit                   fault;
      tcac_pkg::sample_type mean_x;
      tcac_pkg::sample_type mean_y;
      run_sum_y = run_sum_y + tcac_pkg::sum_type'(sample_of(y_word));
      run_sum_x = run_sum_x + tcac_pkg::sum_type'(sample_of(x_word));
      burst_fill++;
      if (burst_fill == tcac_pkg::BURST_PAIRS) begin
         fault = 1'b0;
         mean_x = tcac_pkg::sample_type'(run_sum_x / tcac_pkg::BURST_PAIRS);
         mean_y = tcac_pkg::sample_type'(run_sum_y / tcac_pkg::BURST_PAIRS);
         res.x_pos = map_axis(mean_x, cal_x_min, cal_x_max, cal_x_size, fault);
         res.y_pos = map_axis(mean_y, cal_y_min, cal_y_max, cal_y_size, fault);
         res.span_fault = fault;
         expected_coords.push_back(res);
         burst_fill = 0;
         run_sum_x = '0;
         run_sum_y = '0;
      end
   endtask

   task automatic store_register(input logic [tcac_pkg::CSR_IDX_W-1:0] idx,
                                 input tcac_pkg::sample_type data);
      case (idx)
         tcac_pkg::CSR_X_RAW_MIN: cal_x_min = data;
         tcac_pkg::CSR_X_RAW_MAX: cal_x_max = data;
         tcac_pkg::CSR_X_SIZE:    cal_x_size = data;
         tcac_pkg::CSR_Y_RAW_MIN: cal_y_min = data;
         tcac_pkg::CSR_Y_RAW_MAX: cal_y_max = data;
         tcac_pkg::CSR_Y_SIZE:    cal_y_size = data;
         default: ;
      endcase
   endtask

   function automatic int pick_target(input int lo, input int hi);
      case ($urandom_range(0, 7))
         0: return lo;
         1: return lo + 1;
         2: return hi;
         3: return hi - 1;
         4: return (lo + hi) / 2;
         5: return lo - 1;
         6: return hi + 1;
         default: return int'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic tcac_pkg::word_type make_word(input int aim, input int jitter);
      int s;
      s = aim + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return {1'($urandom_range(0, 1)), tcac_pkg::sample_type'(s),
              3'($urandom_range(0, 7))};
   endfunction

   task automatic queue_bursts(input int count);
      touch_pair_type pair;
      for (int k = 0; k < count; k++) begin
         if (gen_pairs % tcac_pkg::BURST_PAIRS == 0) begin
            burst_noise = ($urandom_range(0, 9) >= 7);
            aim_x = pick_target(calib_next[tcac_pkg::CSR_X_RAW_MIN],
                                calib_next[tcac_pkg::CSR_X_RAW_MAX]);
            aim_y = pick_target(calib_next[tcac_pkg::CSR_Y_RAW_MIN],
                                calib_next[tcac_pkg::CSR_Y_RAW_MAX]);
            spread = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 8));
         end
         if (burst_noise) begin
            pair.y_word = tcac_pkg::word_type'($urandom);
            pair.x_word = tcac_pkg::word_type'($urandom);
         end else begin
            pair.y_word = make_word(aim_y, spread);
            pair.x_word = make_word(aim_x, spread);
         end
         pending_pairs.push_back(pair);
         gen_pairs++;
      end
   endtask

   task automatic load_calib(input tcac_pkg::sample_type x_lo, input tcac_pkg::sample_type x_hi,
                             input tcac_pkg::sample_type x_sz, input tcac_pkg::sample_type y_lo,
                             input tcac_pkg::sample_type y_hi, input tcac_pkg::sample_type y_sz);
      calib_next[tcac_pkg::CSR_X_RAW_MIN] = x_lo;
      calib_next[tcac_pkg::CSR_X_RAW_MAX] = x_hi;
      calib_next[tcac_pkg::CSR_X_SIZE]    = x_sz;
      calib_next[tcac_pkg::CSR_Y_RAW_MIN] = y_lo;
      calib_next[tcac_pkg::CSR_Y_RAW_MAX] = y_hi;
      calib_next[tcac_pkg::CSR_Y_SIZE]    = y_sz;
   endtask

   task automatic set_phase_calibration(input int p);
      for (int i = 0; i < 8; i++) calib_next[i] = tcac_pkg::sample_type'($urandom);
      case (p)
         0: load_calib(12'd0, 12'd4095, 12'd239, 12'd0, 12'd4095, 12'd319);
         1: load_calib(12'd2000, 12'd2000, 12'd4095, 12'd0, 12'd4095, 12'd4095);
         2: load_calib(12'd4000, 12'd100, 12'd4095, 12'd3000, 12'd500, 12'd1000);
         3: load_calib(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095);
         4: load_calib(12'd1000, 12'd1010, 12'd4095, 12'd2000, 12'd2003, 12'd4095);
         6: load_calib(12'd0, 12'd0, 12'd100, 12'd4095, 12'd4095, 12'd200);
         default: ;
      endcase
   endtask

   task automatic program_calibration();
      for (int i = int'(tcac_pkg::CSR_X_RAW_MIN); i <= int'(CSR_UNUSED_HI); i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= tcac_pkg::CSR_IDX_W'(i);
         csr_bus.data  <= calib_next[i];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         store_register(csr_bus.index, csr_bus.data);
      end
      csr_bus.valid <= 1'b0;
      settings_count++;
   endtask

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_FULL:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         PACE_SRC_GAPS:   begin src_idle_pct = 57; snk_stall_pct = 0;  end
         PACE_SNK_STALLS: begin src_idle_pct = 0;  snk_stall_pct = 57; end
         PACE_BOTH:       begin src_idle_pct = 23; snk_stall_pct = 23; end
         default:         begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_bus.valid || expected_coords.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_pair(req_bus.y_word, req_bus.x_word);
            void'(pending_pairs.pop_front());
            pairs_sent++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered request
         end else if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            req_bus.valid  <= 1'b1;
            req_bus.y_word <= pending_pairs[0].y_word;
            req_bus.x_word <= pending_pairs[0].x_word;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_coords.size() == 0) begin
               report_mismatch("result with none pending, x_pos", rsp_bus.x_pos, 0);
            end else begin
               want_coord = expected_coords.pop_front();
               if (rsp_bus.x_pos !== want_coord.x_pos)
                  report_mismatch("x_pos", rsp_bus.x_pos, want_coord.x_pos);
               if (rsp_bus.y_pos !== want_coord.y_pos)
                  report_mismatch("y_pos", rsp_bus.y_pos, want_coord.y_pos);
               if (rsp_bus.span_fault !== want_coord.span_fault)
                  report_mismatch("span_fault", rsp_bus.span_fault, want_coord.span_fault);
            end
         end
         if (hold_go || hold_left != 0)
            rsp_bus.ready <= 1'b0;
         else
            rsp_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      touch_pair_type pair;
      int             count;
      reset = 1'b1;
      hold_go = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.y_word = '0;
      req_bus.x_word = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      cal_x_min = tcac_pkg::X_RAW_MIN_RST;
      cal_x_max = tcac_pkg::X_RAW_MAX_RST;
      cal_x_size = tcac_pkg::X_SIZE_RST;
      cal_y_min = tcac_pkg::Y_RAW_MIN_RST;
      cal_y_max = tcac_pkg::Y_RAW_MAX_RST;
      cal_y_size = tcac_pkg::Y_SIZE_RST;
      run_sum_x = '0;
      run_sum_y = '0;
      burst_fill = 0;
      gen_pairs = 0;
      quiet_cycles = 0;
      mismatch_count = 0;
      pairs_sent = 0;
      results_seen = 0;
      settings_count = 0;
      set_pace(PACE_FULL);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // full-scale Y, zero X, stray bits outside the sample set
      for (int k = 0; k < tcac_pkg::BURST_PAIRS; k++) begin
         pair.y_word = k[0] ? 16'hFFFF : 16'h7FF8;
         pair.x_word = k[0] ? 16'h8007 : 16'h0000;
         pending_pairs.push_back(pair);
         gen_pairs++;
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         set_phase_calibration(p);
         program_calibration();
         set_pace(pace_type'(p % 4));
         count = PHASE_ITEMS;
         if (p == 3 || p == 4) count += tcac_pkg::BURST_PAIRS / 2;
         if (p == PHASES - 1) count += 5;
         queue_bursts(count);
         if (p == PRESSURE_PHASE) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
      end

      wait_drained();
      while (expected_coords.size() != 0) begin
         want_coord = expected_coords.pop_front();
         report_mismatch("result never arrived, x_pos", 0, want_coord.x_pos);
      end
      $display("Covered %0d touch pairs and %0d coordinate results over %0d settings,",
               pairs_sent, results_seen, settings_count);
      $display("with span faults, inverted ranges, clamps, gaps, stalls and a long hold-off.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
